>>> sv/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg: shared types and constants for the k-th smallest select block
// Item structs and sequencer state encoding.
// ----------------------------------------------------------------------------
package kss_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned RANK_W = 11;

  typedef struct packed {
    logic signed [VAL_W-1:0]  value;
    logic                     is_last;
    logic        [RANK_W-1:0] rank_k;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] kth_value;
    logic                    found;
    logic                    overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIV_RD,
    ST_PIV_WT,
    ST_HI_RD,
    ST_HI_WT,
    ST_LO_RD,
    ST_LO_WT,
    ST_SWAP,
    ST_FIN_RD,
    ST_FIN_WT,
    ST_FIN_WR,
    ST_DONE
  } sel_state_t;

endpackage

>>> sv/kss_ram.sv
// ----------------------------------------------------------------------------
// kss_ram: generic single-write, dual-read RAM
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
module kss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> sv/kss_front.sv
// ----------------------------------------------------------------------------
// kss_front: load stage
// Counts elements, drops overflow and queues one select command per set.
// ----------------------------------------------------------------------------
module kss_front #(
  parameter int unsigned MAX_ELEMENTS = kss_pkg::MAX_ELEMENTS_DEF,
  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  kss_pkg::in_item_t in_data,
  output logic              we,
  output logic [AW-1:0]     waddr,
  output logic [kss_pkg::VAL_W-1:0] wdata,
  output logic              cmd_valid,
  output logic [CW-1:0]     cmd_count,
  output logic [kss_pkg::RANK_W-1:0] cmd_rank,
  output logic              cmd_ovf,
  input  logic              cmd_take
);

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          cmd_valid_r;
  logic [CW-1:0] cmd_count_r;
  logic [kss_pkg::RANK_W-1:0] cmd_rank_r;
  logic          cmd_ovf_r;
  logic          acc, room;

  // one-deep command queue; set loading blocks while a set waits
  assign in_full = cmd_valid_r;
  assign acc     = in_push && !in_full;
  assign room    = (count_r < CW'(MAX_ELEMENTS));
  assign we      = acc && room;
  assign waddr   = count_r[AW-1:0];
  assign wdata   = in_data.value;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (acc) begin
      if (room) count_nxt = count_r + CW'(1);
      else      ovf_nxt   = 1'b1;
      if (in_data.is_last) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      cmd_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (acc && in_data.is_last) cmd_valid_r <= 1'b1;
      else if (cmd_take)          cmd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_data.is_last) begin
      cmd_count_r <= room ? count_r + CW'(1) : count_r;
      cmd_rank_r  <= in_data.rank_k;
      cmd_ovf_r   <= ovf_r || !room;
    end
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd_count = cmd_count_r;
  assign cmd_rank  = cmd_rank_r;
  assign cmd_ovf   = cmd_ovf_r;

endmodule

>>> sv/kss_back.sv
// ----------------------------------------------------------------------------
// kss_back: quickselect sequencer
// Hoare partition over the RAM, right scan first, one result per command.
// ----------------------------------------------------------------------------
module kss_back #(
  parameter int unsigned MAX_ELEMENTS = kss_pkg::MAX_ELEMENTS_DEF,
  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  logic [CW-1:0]     cmd_count,
  input  logic [kss_pkg::RANK_W-1:0] cmd_rank,
  input  logic              cmd_ovf,
  output logic              cmd_take,
  output logic              we,
  output logic [AW-1:0]     waddr,
  output logic [kss_pkg::VAL_W-1:0] wdata,
  output logic [AW-1:0]     ra,
  input  logic [kss_pkg::VAL_W-1:0] rda,
  output logic [AW-1:0]     rb,
  input  logic [kss_pkg::VAL_W-1:0] rdb,
  output logic              out_empty,
  input  logic              out_pop,
  output kss_pkg::out_item_t out_data
);

  kss_pkg::sel_state_t st_r, st_nxt;
  logic [AW-1:0] left_r, left_nxt, right_r, right_nxt;
  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, tgt_r, tgt_nxt;
  logic signed [kss_pkg::VAL_W-1:0] piv_r, piv_nxt, vhi_r, vhi_nxt;
  logic ovf_r, ovf_nxt;
  logic res_valid_r, res_valid_nxt;
  kss_pkg::out_item_t res_r, res_nxt;
  // finished result, held until the output register is free
  kss_pkg::out_item_t fin_r, fin_nxt;
  logic in_range;
  logic signed [kss_pkg::VAL_W-1:0] sa;

  assign in_range = (cmd_rank != '0) && (32'(cmd_rank) <= 32'(cmd_count));
  assign sa = rda;

  always_comb begin
    st_nxt = st_r;
    left_nxt = left_r; right_nxt = right_r; lo_nxt = lo_r; hi_nxt = hi_r;
    tgt_nxt = tgt_r; piv_nxt = piv_r; vhi_nxt = vhi_r; fin_nxt = fin_r;
    ovf_nxt = ovf_r; res_valid_nxt = res_valid_r; res_nxt = res_r;
    cmd_take = 1'b0;
    we = 1'b0; waddr = lo_r; wdata = vhi_r;
    ra = lo_r; rb = hi_r;
    if (res_valid_r && out_pop) res_valid_nxt = 1'b0;
    unique case (st_r)
      kss_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          ovf_nxt   = cmd_ovf;
          left_nxt  = '0;
          right_nxt = AW'(cmd_count - CW'(1));
          tgt_nxt   = AW'(cmd_rank - kss_pkg::RANK_W'(1));
          if (in_range) st_nxt = kss_pkg::ST_PIV_RD;
          else begin
            fin_nxt = '{kth_value: '0, found: 1'b0, overflow: cmd_ovf};
            st_nxt  = kss_pkg::ST_DONE;
          end
        end
      end
      kss_pkg::ST_PIV_RD: begin
        ra = left_r; lo_nxt = left_r; hi_nxt = right_r;
        st_nxt = kss_pkg::ST_PIV_WT;
      end
      kss_pkg::ST_PIV_WT: begin
        piv_nxt = sa;
        st_nxt  = (lo_r < hi_r) ? kss_pkg::ST_HI_RD : kss_pkg::ST_FIN_RD;
      end
      kss_pkg::ST_HI_RD: begin
        rb = hi_r; st_nxt = kss_pkg::ST_HI_WT;
      end
      kss_pkg::ST_HI_WT: begin
        if ($signed(rdb) >= piv_r) begin
          hi_nxt = hi_r - AW'(1);
          st_nxt = (lo_r < hi_r - AW'(1)) ? kss_pkg::ST_HI_RD : kss_pkg::ST_FIN_RD;
        end else begin
          vhi_nxt = rdb; st_nxt = kss_pkg::ST_LO_RD;
        end
      end
      kss_pkg::ST_LO_RD: begin
        ra = lo_r; st_nxt = kss_pkg::ST_LO_WT;
      end
      kss_pkg::ST_LO_WT: begin
        if (sa <= piv_r) begin
          lo_nxt = lo_r + AW'(1);
          st_nxt = (lo_r + AW'(1) < hi_r) ? kss_pkg::ST_LO_RD : kss_pkg::ST_FIN_RD;
        end else begin
          // write hi value to lo, then lo value (held in vhi) to hi
          we = 1'b1; waddr = lo_r; wdata = vhi_r;
          vhi_nxt = sa; st_nxt = kss_pkg::ST_SWAP;
        end
      end
      kss_pkg::ST_SWAP: begin
        // after swap element at hi is > pivot: hi scan steps it down next
        we = 1'b1; waddr = hi_r; wdata = vhi_r;
        st_nxt = kss_pkg::ST_HI_RD;
      end
      kss_pkg::ST_FIN_RD: begin
        ra = lo_r; st_nxt = kss_pkg::ST_FIN_WT;
      end
      kss_pkg::ST_FIN_WT: begin
        // exchange(lo, left): pivot goes to lo, old lo value to left
        we = 1'b1; waddr = left_r; wdata = sa;
        st_nxt = kss_pkg::ST_FIN_WR;
      end
      kss_pkg::ST_FIN_WR: begin
        we = 1'b1; waddr = lo_r; wdata = piv_r;
        if (lo_r == tgt_r) begin
          fin_nxt = '{kth_value: piv_r, found: 1'b1, overflow: ovf_r};
          st_nxt  = kss_pkg::ST_DONE;
        end else if (lo_r < tgt_r) begin
          left_nxt = lo_r + AW'(1); st_nxt = kss_pkg::ST_PIV_RD;
        end else begin
          right_nxt = lo_r - AW'(1); st_nxt = kss_pkg::ST_PIV_RD;
        end
      end
      kss_pkg::ST_DONE: begin
        // set is finished: release the command, front may load again
        if (!res_valid_r || out_pop) begin
          res_valid_nxt = 1'b1; res_nxt = fin_r;
          cmd_take = 1'b1;
          st_nxt = kss_pkg::ST_IDLE;
        end
      end
      default: st_nxt = kss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= kss_pkg::ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt; right_r <= right_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    tgt_r <= tgt_nxt; piv_r <= piv_nxt; vhi_r <= vhi_nxt; ovf_r <= ovf_nxt;
    res_r <= res_nxt; fin_r <= fin_nxt;
  end

  assign out_empty = !res_valid_r;
  assign out_data  = res_r;

endmodule

>>> sv/kth_smallest_select_core.sv
// ----------------------------------------------------------------------------
// kth_smallest_select_core: k-th smallest value of a loaded set
// Front loads a set into RAM; back runs in-place quickselect and emits one item.
// ----------------------------------------------------------------------------
// channel | ports                    | accept
// input   | in_push in_full in_data  | push && !full
// result  | out_pop out_empty out_data | pop && !empty
//
// While in_full is low, loading takes one item per cycle into the RAM write port.
// Selection: each scan step waits on a registered RAM read, a swap adds a write,
// and each partition round adds pivot fetch and placement; plus start and finish.
// in_full stays high from the last item of a set until the back has finished
// that set and moved its item into the result register.
// The back holds in its last state while an older item waits unpopped.
// Synchronous active-low reset; no clearing pass, the RAM needs none.
// ----------------------------------------------------------------------------
module kth_smallest_select_core #(
  parameter int unsigned MAX_ELEMENTS = kss_pkg::MAX_ELEMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  kss_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output kss_pkg::out_item_t out_data
);

  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  logic f_we, b_we, cmd_valid, cmd_take, cmd_ovf;
  logic [AW-1:0] f_wa, b_wa, ra, rb;
  logic [kss_pkg::VAL_W-1:0] f_wd, b_wd, rda, rdb;
  logic [CW-1:0] cmd_count;
  logic [kss_pkg::RANK_W-1:0] cmd_rank;

  kss_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .we(f_we), .waddr(f_wa), .wdata(f_wd),
    .cmd_valid, .cmd_count, .cmd_rank, .cmd_ovf, .cmd_take
  );

  // front writes only while back is idle (set waiting blocks loading)
  kss_ram #(.WIDTH(kss_pkg::VAL_W), .DEPTH(MAX_ELEMENTS)) u_ram (
    .clk, .we(f_we || b_we),
    .waddr(f_we ? f_wa : b_wa), .wdata(f_we ? f_wd : b_wd),
    .raddr_a(ra), .rdata_a(rda), .raddr_b(rb), .rdata_b(rdb)
  );

  kss_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_count, .cmd_rank, .cmd_ovf, .cmd_take,
    .we(b_we), .waddr(b_wa), .wdata(b_wd), .ra, .rda, .rb, .rdb,
    .out_empty, .out_pop, .out_data
  );

endmodule

>>> sv/kss_checker.sv
// ----------------------------------------------------------------------------
// kss_checker: port-level assertions for kth_smallest_select_core
// Result channel stability, found/value coherence and reset state.
// ----------------------------------------------------------------------------
module kss_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input kss_pkg::out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result changed while stalled");

  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.found) |-> (out_data.kth_value == '0))
    else $error("not-found result carries a value");

  a_rst: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("reset state wrong");

endmodule

bind kth_smallest_select_core kss_checker u_kss_checker (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_data
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for kth_smallest_select_core
// Loads sets of signed values with random push/pop gaps and checks each
// result item against an in-bench quickselect model or a directed expectation.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DEPTH      = kss_pkg::MAX_ELEMENTS_DEF;
  localparam int unsigned CYCLE_CAP  = 3000000;
  localparam int unsigned DRAIN_WAIT = 64;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  kss_pkg::in_item_t  in_data;
  logic               out_empty;
  logic               out_pop;
  kss_pkg::out_item_t out_data;

  kth_smallest_select_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  // shadow of the block: element buffer, fill level, dropped-element flag
  logic signed [kss_pkg::VAL_W-1:0] set_buf [DEPTH];
  int unsigned                      set_fill;
  bit                               set_dropped;

  kss_pkg::out_item_t pending_picks[$];
  int unsigned errors;
  int unsigned cycles;

  // directed rows; exp_* used only where typed_exp is set
  typedef struct {
    logic signed [kss_pkg::VAL_W-1:0] value;
    bit                               last;
    logic [kss_pkg::RANK_W-1:0]       rank;
    bit                               typed_exp;
    logic signed [kss_pkg::VAL_W-1:0] exp_value;
    bit                               exp_found;
  } dir_row_t;

  localparam int DIR_ROWS = 18;
  dir_row_t dir_rows [DIR_ROWS] = '{
    // rank zero never selects
    '{32'sd5, 1'b1, 11'd0, 1'b1, 32'sd0, 1'b0},
    // both extremes of the value range
    '{32'sh8000_0000, 1'b0, 11'd0, 1'b0, 32'sd0, 1'b0},
    '{32'sh7fff_ffff, 1'b0, 11'd0, 1'b0, 32'sd0, 1'b0},
    '{32'sd0,          1'b1, 11'd1, 1'b1, 32'sh8000_0000, 1'b1},
    '{32'sh7fff_ffff, 1'b1, 11'd1, 1'b1, 32'sh7fff_ffff, 1'b1},
    // rank past the fill level
    '{32'sd3, 1'b0, 11'd0, 1'b0, 32'sd0, 1'b0},
    '{32'sd1, 1'b0, 11'd0, 1'b0, 32'sd0, 1'b0},
    '{32'sd2, 1'b1, 11'd4, 1'b1, 32'sd0, 1'b0},
    // all rank bits set
    '{-32'sd9, 1'b1, 11'h7ff, 1'b1, 32'sd0, 1'b0},
    // duplicates around the pivot
    '{32'sd7, 1'b0, 11'd0, 1'b0, 32'sd0, 1'b0},
    '{32'sd7, 1'b0, 11'd0, 1'b0, 32'sd0, 1'b0},
    '{-32'sd7, 1'b1, 11'd2, 1'b1, 32'sd7, 1'b1},
    // descending then max rank of the set, model-checked
    '{32'sd40, 1'b0, 11'd0, 1'b0, 32'sd0, 1'b0},
    '{32'sd30, 1'b0, 11'd0, 1'b0, 32'sd0, 1'b0},
    '{32'sd20, 1'b0, 11'd0, 1'b0, 32'sd0, 1'b0},
    '{-32'sd1, 1'b1, 11'd4, 1'b0, 32'sd0, 1'b0},
    '{32'sd11, 1'b0, 11'd0, 1'b0, 32'sd0, 1'b0},
    '{32'sd12, 1'b1, 11'd1, 1'b0, 32'sd0, 1'b0}
  };

  // in-place quickselect, pivot = first of range, right scan first
  function automatic logic signed [kss_pkg::VAL_W-1:0] pick_rank(int unsigned cnt,
                                                                 int unsigned tgt);
    int unsigned left, right, lo, hi;
    logic signed [kss_pkg::VAL_W-1:0] pivot, tmp;
    left  = 0;
    right = cnt - 1;
    forever begin
      lo    = left;
      hi    = right;
      pivot = set_buf[left];
      while (lo < hi) begin
        if (set_buf[hi] >= pivot) hi--;
        else if (set_buf[lo] <= pivot) lo++;
        else begin
          tmp = set_buf[lo]; set_buf[lo] = set_buf[hi]; set_buf[hi] = tmp;
        end
      end
      tmp = set_buf[lo]; set_buf[lo] = set_buf[left]; set_buf[left] = tmp;
      if (lo == tgt) return set_buf[lo];
      if (lo < tgt) left = lo + 1;
      else right = lo - 1;
      if (left > right || right >= cnt) return '0;
    end
  endfunction

  // accepted item -> shadow update; returns 1 when a result is due
  function automatic bit load_and_pick(kss_pkg::in_item_t it, output kss_pkg::out_item_t res);
    if (set_fill < DEPTH) begin
      set_buf[set_fill] = it.value;
      set_fill++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!it.is_last) return 1'b0;
    res.found     = (it.rank_k >= 1) && (it.rank_k <= set_fill);
    res.kth_value = res.found ? pick_rank(set_fill, it.rank_k - 1) : '0;
    res.overflow  = set_dropped;
    set_fill    = 0;
    set_dropped = 1'b0;
    return 1'b1;
  endfunction

  // push drops only while a gap is taken
  task automatic idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return;
    in_push <= 1'b0;
    if (roll < 93) repeat ($urandom_range(1, 3)) @(negedge clk);
    else repeat ($urandom_range(10, 40)) @(negedge clk);
  endtask

  // drive one item at the falling edge, hold until accepted
  task automatic push_item(kss_pkg::in_item_t it, bit typed, kss_pkg::out_item_t typed_res);
    kss_pkg::out_item_t res;
    idle_gap();
    in_push <= 1'b1;
    in_data <= it;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    if (load_and_pick(it, res)) pending_picks.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  function automatic logic signed [kss_pkg::VAL_W-1:0] rand_value(int unsigned style);
    case (style)
      0: return $signed(kss_pkg::VAL_W'($urandom_range(0, 7))) - 32'sd3;
      1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic send_set(int unsigned n, bit sorted);
    kss_pkg::in_item_t  it;
    kss_pkg::out_item_t none;
    int unsigned style, pick;
    none  = '0;
    style = $urandom_range(0, 3);
    for (int unsigned i = 0; i < n; i++) begin
      it.value   = sorted ? $signed(kss_pkg::VAL_W'(i))
                          : rand_value(style == 1 ? $urandom_range(0, 2) : style);
      it.is_last = (i == n - 1);
      pick = $urandom_range(0, 19);
      if (!it.is_last) it.rank_k = kss_pkg::RANK_W'($urandom());
      else if (pick == 0) it.rank_k = '0;
      else if (pick == 1) it.rank_k = kss_pkg::RANK_W'($urandom_range(n < 2047 ? n : 2047, 2047));
      else it.rank_k = kss_pkg::RANK_W'($urandom_range(1, n < DEPTH ? n : DEPTH));
      push_item(it, 1'b0, none);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // random pop pressure, with long stretches of no pops
  initial begin
    int unsigned roll;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      roll = $urandom_range(0, 99);
      if (roll < 60) out_pop <= 1'b1;
      else if (roll < 95) out_pop <= 1'b0;
      else begin
        out_pop <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    kss_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected item got %p", $time, out_data);
        errors++;
      end else begin
        want = pending_picks.pop_front();
        if (out_data.kth_value !== want.kth_value) begin
          $display("%0t: kth_value exp %0d got %0d", $time, want.kth_value, out_data.kth_value);
          errors++;
        end
        if (out_data.found !== want.found) begin
          $display("%0t: found exp %0b got %0b", $time, want.found, out_data.found);
          errors++;
        end
        if (out_data.overflow !== want.overflow) begin
          $display("%0t: overflow exp %0b got %0b", $time, want.overflow, out_data.overflow);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    kss_pkg::in_item_t  it;
    kss_pkg::out_item_t typed_res;
    int unsigned sent;
    bit          paused;
    errors      = 0;
    cycles      = 0;
    set_fill    = 0;
    set_dropped = 1'b0;
    paused      = 1'b0;
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_data     = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      it.value            = dir_rows[r].value;
      it.is_last          = dir_rows[r].last;
      it.rank_k           = dir_rows[r].rank;
      typed_res.kth_value = dir_rows[r].exp_value;
      typed_res.found     = dir_rows[r].exp_found;
      typed_res.overflow  = 1'b0;
      push_item(it, dir_rows[r].typed_exp, typed_res);
    end

    // random sets: mostly small, a few larger ones
    sent = 0;
    while (sent < 1000) begin
      int unsigned n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      send_set(n, $urandom_range(0, 15) == 0);
      sent += n;
      if (!paused && sent > 500) begin
        // hold off until every pending result has drained
        paused = 1'b1;
        in_push <= 1'b0;
        while (pending_picks.size() != 0) @(negedge clk);
      end
    end

    in_push <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
sv/kss_pkg.sv
sv/kss_ram.sv
sv/kss_front.sv
sv/kss_back.sv
sv/kth_smallest_select_core.sv
sv/kss_checker.sv
tb/tb_top.sv
